[sv/bcfc_pkg.sv]
package bcfc_pkg;

   localparam logic [7:0] START_BYTE       = 8'hAA;
   localparam logic [7:0] STATUS_RESP_BYTE = 8'h80;
   localparam logic [7:0] STATUS_PAD_BYTE  = 8'h00;
   localparam logic [7:0] CMD_TOGGLE_A     = 8'h01;
   localparam logic [7:0] CMD_TOGGLE_B     = 8'h02;
   localparam logic [7:0] CMD_TOGGLE_C     = 8'h03;
   localparam logic [7:0] CMD_BLINK_FAST   = 8'h04;
   localparam logic [7:0] CMD_BRIGHTNESS   = 8'h05;
   localparam logic [7:0] CMD_STATUS       = 8'h06;

   localparam int VALUE_W = 12;
   localparam int DUTY_W  = 13;
   localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd4095;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int STATUS_BEATS = 5;
   localparam int BEAT_W       = $clog2(STATUS_BEATS);

   typedef enum logic [1:0] {
      LED_OFF        = 2'd0,
      LED_BLINK_SLOW = 2'd1,
      LED_BLINK_FAST = 2'd2,
      LED_SET_BRIGHT = 2'd3
   } led_action_type;

   typedef enum logic [0:0] {
      KIND_LED = 1'b0,
      KIND_TX  = 1'b1
   } result_kind_type;

   typedef enum logic [1:0] {
      CLASS_TOGGLE = 2'd0,
      CLASS_FAST   = 2'd1,
      CLASS_BRIGHT = 2'd2,
      CLASS_STATUS = 2'd3
   } cmd_class_type;

   typedef struct packed {
      cmd_class_type       cls;
      logic [DUTY_W-1:0]   duty;
   } cmd_entry_type;

   typedef struct packed {
      logic          push;
      cmd_entry_type entry;
   } push_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

[sv/bcfc_frame_parser.sv]
module bcfc_frame_parser import bcfc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_rx_byte,
   input  queue_status_type qstat,
   output push_type         push_out
);

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_CMD   = 3'd1,
      PH_VLO   = 3'd2,
      PH_VHI   = 3'd3,
      PH_CHECK = 3'd4
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [7:0]         cmd_ff, cmd_in;
   logic [7:0]         vlo_ff, vlo_in;
   logic [7:0]         vhi_ff, vhi_in;
   logic               accept;
   logic [7:0]         chk;
   logic               known;
   cmd_class_type      cls;
   logic [VALUE_W-1:0] value12;
   logic [DUTY_W-1:0]  duty;

   assign req_ready = !qstat.full;
   assign accept    = req_valid && req_ready;
   assign chk       = START_BYTE ^ cmd_ff ^ vlo_ff ^ vhi_ff;
   assign value12   = {vhi_ff[3:0], vlo_ff};
   assign duty      = {value12, (value12 == MAX_VALUE)};

   always_comb begin
      known = 1'b1;
      cls   = CLASS_TOGGLE;
      case (cmd_ff) inside
         [CMD_TOGGLE_A:CMD_TOGGLE_C]: cls = CLASS_TOGGLE;
         CMD_BLINK_FAST: cls = CLASS_FAST;
         CMD_BRIGHTNESS: begin
            cls   = CLASS_BRIGHT;
            known = (vhi_ff[7:4] == 4'd0);
         end
         CMD_STATUS: cls = CLASS_STATUS;
         default: known = 1'b0;
      endcase
   end

   always_comb begin
      phase_in            = phase_ff;
      cmd_in              = cmd_ff;
      vlo_in              = vlo_ff;
      vhi_in              = vhi_ff;
      push_out.push       = 1'b0;
      push_out.entry.cls  = cls;
      push_out.entry.duty = duty;
      if (accept) begin
         case (phase_ff)
            PH_HUNT: phase_in = (req_rx_byte == START_BYTE) ? PH_CMD : PH_HUNT;
            PH_CMD: begin
               cmd_in   = req_rx_byte;
               phase_in = PH_VLO;
            end
            PH_VLO: begin
               vlo_in   = req_rx_byte;
               phase_in = PH_VHI;
            end
            PH_VHI: begin
               vhi_in   = req_rx_byte;
               phase_in = PH_CHECK;
            end
            PH_CHECK: begin
               push_out.push = (chk == req_rx_byte) && known;
               phase_in      = PH_HUNT;
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         cmd_ff   <= 8'd0;
         vlo_ff   <= 8'd0;
         vhi_ff   <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         vlo_ff   <= vlo_in;
         vhi_ff   <= vhi_in;
      end
   end

endmodule

[sv/bcfc_cmd_queue.sv]
module bcfc_cmd_queue import bcfc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  push_type         push_in,
   input  logic             pop,
   output cmd_entry_type    head,
   output queue_status_type qstat
);

   cmd_entry_type          entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign qstat.full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign qstat.not_empty = (count_ff != '0);
   assign do_push         = push_in.push && !qstat.full;
   assign do_pop          = pop && qstat.not_empty;
   assign head            = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

endmodule

[sv/bcfc_executor.sv]
module bcfc_executor import bcfc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_entry_type     head,
   input  queue_status_type  qstat,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [1:0]        rsp_led_action,
   output logic [DUTY_W-1:0] rsp_duty,
   output logic [7:0]        rsp_tx_byte,
   output logic              rsp_last
);

   logic              active_ff, active_in;
   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic              valid_ff, valid_in;
   result_kind_type   kind_ff, kind_in;
   led_action_type    action_ff, action_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic [7:0]        tx_ff, tx_in;
   logic              last_ff, last_in;
   logic              load_ok;
   logic              load;
   logic [7:0]        active_byte;

   assign load_ok     = !valid_ff || rsp_ready;
   assign active_byte = {7'd0, active_ff};

   always_comb begin
      active_in = active_ff;
      beat_in   = beat_ff;
      valid_in  = valid_ff && !rsp_ready;
      kind_in   = kind_ff;
      action_in = action_ff;
      duty_in   = duty_ff;
      tx_in     = tx_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      load      = 1'b0;
      if (qstat.not_empty && load_ok) begin
         kind_in   = KIND_LED;
         action_in = LED_OFF;
         duty_in   = '0;
         tx_in     = 8'd0;
         last_in   = 1'b1;
         case (head.cls)
            CLASS_TOGGLE: begin
               load      = 1'b1;
               pop       = 1'b1;
               action_in = active_ff ? LED_OFF : LED_BLINK_SLOW;
               active_in = !active_ff;
            end
            CLASS_FAST: begin
               load      = active_ff;
               pop       = 1'b1;
               action_in = LED_BLINK_FAST;
            end
            CLASS_BRIGHT: begin
               load      = active_ff;
               pop       = 1'b1;
               action_in = LED_SET_BRIGHT;
               duty_in   = head.duty;
            end
            CLASS_STATUS: begin
               load    = 1'b1;
               kind_in = KIND_TX;
               last_in = (beat_ff == BEAT_W'(STATUS_BEATS - 1));
               case (beat_ff)
                  BEAT_W'(0): tx_in = START_BYTE;
                  BEAT_W'(1): tx_in = STATUS_RESP_BYTE;
                  BEAT_W'(2): tx_in = active_byte;
                  BEAT_W'(3): tx_in = STATUS_PAD_BYTE;
                  default:    tx_in = START_BYTE ^ STATUS_RESP_BYTE ^ active_byte;
               endcase
               if (last_in) begin
                  pop     = 1'b1;
                  beat_in = '0;
               end else begin
                  beat_in = beat_ff + 1'b1;
               end
            end
            default: pop = 1'b1;
         endcase
         if (load) begin
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         beat_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         beat_ff   <= beat_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= kind_in;
         action_ff <= action_in;
         duty_ff   <= duty_in;
         tx_ff     <= tx_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_led_action = action_ff;
   assign rsp_duty       = duty_ff;
   assign rsp_tx_byte    = tx_ff;
   assign rsp_last       = last_ff;

endmodule

[sv/binary_command_frame_controller_core.sv]
// A valid frame's command enters the queue as its check byte is accepted, and its result
// is then registered at the output. Throughput: one input byte per cycle; the executor
// issues one result per cycle while rsp_ready is high, so a status command occupies it
// for five beats while the four-entry queue absorbs input. Input is held off whenever
// the command queue is full. Reset is synchronous and active high; it returns to hunting
// for the start byte with the system off and the queue and output register empty.
module binary_command_frame_controller_core import bcfc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [1:0]        rsp_led_action,
   output logic [DUTY_W-1:0] rsp_duty,
   output logic [7:0]        rsp_tx_byte,
   output logic              rsp_last
);

   push_type         push_bus;
   queue_status_type qstat;
   cmd_entry_type    head;
   logic             pop;

   bcfc_frame_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .qstat       (qstat),
      .push_out    (push_bus)
   );

   bcfc_cmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push_bus),
      .pop     (pop),
      .head    (head),
      .qstat   (qstat)
   );

   bcfc_executor u_exec (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .qstat          (qstat),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_led_action (rsp_led_action),
      .rsp_duty       (rsp_duty),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_last       (rsp_last)
   );

endmodule

[sv/bcfc_checker.sv]
module bcfc_checker import bcfc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_kind,
   input logic [1:0]        rsp_led_action,
   input logic [DUTY_W-1:0] rsp_duty,
   input logic [7:0]        rsp_tx_byte,
   input logic              rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_led_action) && $stable(rsp_duty) && $stable(rsp_tx_byte) &&
      $stable(rsp_last))
      else $error("Stalled result transaction changed.");

   a_led_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_LED) |-> rsp_last && (rsp_tx_byte == 8'd0))
      else $error("LED result transaction is not a single final one.");

   a_duty_only_bright: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_led_action != LED_SET_BRIGHT) |-> (rsp_duty == '0))
      else $error("Duty is non-zero outside set brightness.");

   a_tx_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_TX) |-> (rsp_led_action == LED_OFF) &&
      (rsp_duty == '0))
      else $error("Status byte transaction carries LED fields.");

   a_start_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_kind == KIND_TX) && (rsp_tx_byte == START_BYTE)
      |=> !rsp_valid || ((rsp_kind == KIND_TX) && !rsp_last))
      else $error("Status frame ended early after its start byte.");

endmodule

bind binary_command_frame_controller_core bcfc_checker u_bcfc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_kind       (rsp_kind),
   .rsp_led_action (rsp_led_action),
   .rsp_duty       (rsp_duty),
   .rsp_tx_byte    (rsp_tx_byte),
   .rsp_last       (rsp_last)
);

[tb/binary_command_frame_controller_core_tb.sv]
module binary_command_frame_controller_core_tb;
   import bcfc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int QUIET_FROM = 200;
   localparam int QUIET_TO = 700;
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_BYTES = 244;
   localparam logic [DUTY_W-1:0] FULL_DUTY = DUTY_W'((1 << DUTY_W) - 1);

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_CMD   = 3'd1,
      PH_LO    = 3'd2,
      PH_HI    = 3'd3,
      PH_CHECK = 3'd4
   } frame_phase_type;

   typedef struct packed {
      result_kind_type   kind;
      led_action_type    action;
      logic [DUTY_W-1:0] duty;
      logic [7:0]        tx_byte;
      logic              last;
   } frame_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_rx_byte = 8'h00;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_kind;
   logic [1:0]        rsp_led_action;
   logic [DUTY_W-1:0] rsp_duty;
   logic [7:0]        rsp_tx_byte;
   logic              rsp_last;

   logic [7:0]       rx_byte_q[$];
   frame_result_type expected_q[$];
   int               total_bytes = 0;
   int               bytes_accepted = 0;
   int               results_seen = 0;
   int               mismatch_count = 0;
   int               drv_cycle = 0;
   int               mon_cycle = 0;
   int               hold_left = 0;
   bit               hold_done = 1'b0;
   int               stall_cycles = 0;

   frame_phase_type  phase = PH_HUNT;
   logic [7:0]       cmd_code = 8'h00;
   logic [15:0]      value_word = 16'h0000;
   logic             system_active = 1'b0;

   binary_command_frame_controller_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_led_action(rsp_led_action),
      .rsp_duty      (rsp_duty),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last      (rsp_last)
   );

   always #5 clock = ~clock;

   task automatic push_led(input led_action_type action, input logic [DUTY_W-1:0] duty);
      expected_q.push_back('{KIND_LED, action, duty, 8'h00, 1'b1});
   endtask

   task automatic predict_frame_byte(input logic [7:0] b);
      logic [7:0] check;
      logic [7:0] status[STATUS_BEATS];
      case (phase)
         PH_CMD: begin
            cmd_code = b;
            phase = PH_LO;
         end
         PH_LO: begin
            value_word = {8'h00, b};
            phase = PH_HI;
         end
         PH_HI: begin
            value_word = {b, value_word[7:0]};
            phase = PH_CHECK;
         end
         PH_CHECK: begin
            check = START_BYTE ^ cmd_code ^ value_word[7:0] ^ value_word[15:8];
            phase = PH_HUNT;
            if (check == b) begin
               case (cmd_code)
                  CMD_TOGGLE_A, CMD_TOGGLE_B, CMD_TOGGLE_C: begin
                     system_active = !system_active;
                     push_led(system_active ? LED_BLINK_SLOW : LED_OFF, '0);
                  end
                  CMD_BLINK_FAST: begin
                     if (system_active)
                        push_led(LED_BLINK_FAST, '0);
                  end
                  CMD_BRIGHTNESS: begin
                     if (system_active && value_word <= MAX_VALUE)
                        push_led(LED_SET_BRIGHT,
                                 DUTY_W'((32'(value_word) * FULL_DUTY) / MAX_VALUE));
                  end
                  CMD_STATUS: begin
                     status[0] = START_BYTE;
                     status[1] = STATUS_RESP_BYTE;
                     status[2] = {7'b0, system_active};
                     status[3] = STATUS_PAD_BYTE;
                     status[4] = status[0] ^ status[1] ^ status[2] ^ status[3];
                     for (int i = 0; i < STATUS_BEATS; i++)
                        expected_q.push_back('{KIND_TX, LED_OFF, '0, status[i],
                                               i == STATUS_BEATS - 1});
                  end
                  default: ;
               endcase
            end
         end
         default: begin
            phase = (b == START_BYTE) ? PH_CMD : PH_HUNT;
         end
      endcase
   endtask

   task automatic add_frame(input logic [7:0] cmd, input logic [15:0] value, input bit corrupt);
      logic [7:0] check;
      check = START_BYTE ^ cmd ^ value[7:0] ^ value[15:8];
      if (corrupt)
         check = check ^ 8'($urandom_range(1, 255));
      rx_byte_q.push_back(START_BYTE);
      rx_byte_q.push_back(cmd);
      rx_byte_q.push_back(value[7:0]);
      rx_byte_q.push_back(value[15:8]);
      rx_byte_q.push_back(check);
   endtask

   task automatic note_mismatch(input string what, input frame_result_type want,
                                input frame_result_type seen);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display({"%0t: %s: expected kind %0d action %0d duty %0d tx %02h last %0d,",
                   " got kind %0d action %0d duty %0d tx %02h last %0d"},
                  $realtime, what, want.kind, want.action, want.duty, want.tx_byte,
                  want.last, seen.kind, seen.action, seen.duty, seen.tx_byte, seen.last);
   endtask

   always @(posedge clock) begin : byte_driver
      bit idle;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         drv_cycle++;
         if (req_valid && req_ready) begin
            predict_frame_byte(req_rx_byte);
            bytes_accepted++;
         end
         if (!req_valid || req_ready) begin
            idle = (drv_cycle < QUIET_FROM || drv_cycle > QUIET_TO) &&
                   ($urandom_range(99) < 20);
            if (!idle && rx_byte_q.size() != 0) begin
               req_valid <= 1'b1;
               req_rx_byte <= rx_byte_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      frame_result_type seen;
      frame_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         mon_cycle++;
         if (rsp_valid && rsp_ready) begin
            seen = '{result_kind_type'(rsp_kind), led_action_type'(rsp_led_action),
                     rsp_duty, rsp_tx_byte, rsp_last};
            results_seen++;
            if (expected_q.size() == 0) begin
               note_mismatch("unexpected result", '0, seen);
            end else begin
               want = expected_q.pop_front();
               if (seen !== want)
                  note_mismatch("result mismatch", want, seen);
            end
         end
         // The receiver holds off once for a long stretch so that the command queue fills.
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && results_seen >= 20) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !((mon_cycle < QUIET_FROM || mon_cycle > QUIET_TO) &&
                           ($urandom_range(99) < 20));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int pick;
      int directed_bytes;
      logic [7:0] cmd;
      logic [15:0] value;

      rx_byte_q.push_back(8'hFF);
      add_frame(CMD_BLINK_FAST, 16'h0000, 1'b0);
      add_frame(CMD_TOGGLE_A, 16'hFFFF, 1'b0);
      add_frame(CMD_BRIGHTNESS, 16'(MAX_VALUE), 1'b0);
      add_frame(CMD_STATUS, 16'h0000, 1'b0);
      add_frame(CMD_TOGGLE_B, 16'h1234, 1'b1);
      directed_bytes = rx_byte_q.size();

      while (rx_byte_q.size() < directed_bytes + RANDOM_BYTES) begin
         pick = $urandom_range(99);
         if ($urandom_range(9) != 0)
            cmd = 8'($urandom_range(1, 6));
         else
            cmd = 8'($urandom_range(0, 255));
         case ($urandom_range(9))
            0: value = 16'h0000;
            1: value = 16'(MAX_VALUE) + 16'd1;
            2: value = 16'($urandom_range(0, 65535));
            3: value = 16'hFFFF;
            default: value = 16'($urandom_range(0, 4095));
         endcase
         if (pick < 75) begin
            add_frame(cmd, value, 1'b0);
         end else if (pick < 85) begin
            add_frame(cmd, value, 1'b1);
         end else if (pick < 92) begin
            rx_byte_q.push_back(START_BYTE);
            repeat ($urandom_range(1, 3))
               rx_byte_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 4))
               rx_byte_q.push_back(8'($urandom_range(0, 255)));
         end
      end
      total_bytes = rx_byte_q.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (bytes_accepted < total_bytes)
         @(posedge clock);
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
